[rtl/core/lkvt_pkg.sv]
// shared types and constants for the linear key-value table
package lkvt_pkg;

   localparam int CAPACITY_ENTRIES = 32;
   localparam int KEY_BITS         = 16;
   localparam int VALUE_BITS       = 32;
   localparam int IDX_BITS         = $clog2(CAPACITY_ENTRIES);
   localparam int CNT_BITS         = $clog2(CAPACITY_ENTRIES + 1);
   localparam int ENTRY_BITS       = KEY_BITS + VALUE_BITS;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_DUPLICATE = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_ABSENT    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SHIFT
   } state_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] key;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [31:0] read_value;
      logic [1:0]  status;
      logic [5:0]  entry_total;
      logic        is_full;
   } rsp_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } entry_type;

endpackage

[rtl/core/linear_key_value_table_unit.sv]
// linear key-value table: packed entry ram searched and compacted one entry per cycle
// the search stops at a hit, or after the last entry on a miss (after the first compare when
// empty); a delete hit before the last entry strobes only after the later entries shift down
// the search and the compaction both go through the one read port of the entry ram
// busy drops in the strobe cycle, so a new item is taken only once the last one is through
// synchronous reset empties the table by clearing the count; ram contents are left as they are
module linear_key_value_table_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lkvt_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output lkvt_pkg::rsp_type rsp_payload
);

   // control and count
   lkvt_pkg::state_type              state_ff, state_in;
   logic [lkvt_pkg::CNT_BITS-1:0]    count_ff, count_in;
   // index of the entry whose read data arrives this cycle
   logic [lkvt_pkg::IDX_BITS-1:0]    rd_idx_ff, rd_idx_in;
   // latched item and result
   lkvt_pkg::req_type                req_ff, req_in;
   lkvt_pkg::rsp_type                rsp_ff, rsp_in;
   logic                             strobe_ff, strobe_in;

   // entry ram ports
   logic                             ram_wr_en;
   logic [lkvt_pkg::IDX_BITS-1:0]    ram_wr_addr;
   lkvt_pkg::entry_type              ram_wr_data;
   logic [lkvt_pkg::IDX_BITS-1:0]    ram_rd_addr;
   lkvt_pkg::entry_type              ram_rd_data;

   // search helpers
   logic [lkvt_pkg::CNT_BITS-1:0]    idx_next_cnt;
   logic                             key_hit;
   logic                             last_entry;

   lkvt_ram #(
      .WIDTH (lkvt_pkg::ENTRY_BITS),
      .DEPTH (lkvt_pkg::CAPACITY_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // one past the entry under compare, at count width
   assign idx_next_cnt = lkvt_pkg::CNT_BITS'(rd_idx_ff) + lkvt_pkg::CNT_BITS'(1);
   // an empty table never hits, whatever the ram returns
   assign key_hit    = (count_ff != '0) &&
                       (ram_rd_data.key == req_ff.key[lkvt_pkg::KEY_BITS-1:0]);
   assign last_entry = (count_ff == '0) || (idx_next_cnt == count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= lkvt_pkg::ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      rd_idx_in   = rd_idx_ff;
      req_in      = req_ff;
      rsp_in      = rsp_ff;
      strobe_in   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = rd_idx_ff - lkvt_pkg::IDX_BITS'(1);
      ram_wr_data = ram_rd_data;
      // prefetch the following entry; wraps harmlessly past the last one
      ram_rd_addr = rd_idx_ff + lkvt_pkg::IDX_BITS'(1);

      unique case (state_ff)
         lkvt_pkg::ST_IDLE: begin
            ram_rd_addr = '0;
            if (start) begin
               req_in    = req_payload;
               rd_idx_in = '0;
               state_in  = lkvt_pkg::ST_SEARCH;
            end
         end

         lkvt_pkg::ST_SEARCH: begin
            rd_idx_in = ram_rd_addr;
            if (key_hit || last_entry) begin
               // default result for this item, refined below
               rsp_in.found      = key_hit;
               rsp_in.read_value = '0;
               rsp_in.status     = lkvt_pkg::STATUS_DONE;
               strobe_in         = 1'b1;
               state_in          = lkvt_pkg::ST_IDLE;
               if (key_hit) begin
                  unique case (req_ff.operation)
                     lkvt_pkg::OP_LOOKUP: begin
                        rsp_in.read_value = 32'(ram_rd_data.value);
                     end
                     lkvt_pkg::OP_INSERT: begin
                        rsp_in.status = lkvt_pkg::STATUS_DUPLICATE;
                     end
                     lkvt_pkg::OP_DELETE: begin
                        if (last_entry) begin
                           count_in = count_ff - lkvt_pkg::CNT_BITS'(1);
                        end else begin
                           // compact: later entries move down one place
                           strobe_in = 1'b0;
                           state_in  = lkvt_pkg::ST_SHIFT;
                        end
                     end
                     default: begin
                     end
                  endcase
               end else begin
                  unique case (req_ff.operation)
                     lkvt_pkg::OP_LOOKUP: begin
                        rsp_in.status = lkvt_pkg::STATUS_ABSENT;
                     end
                     lkvt_pkg::OP_INSERT: begin
                        if (count_ff == lkvt_pkg::CNT_BITS'(lkvt_pkg::CAPACITY_ENTRIES)) begin
                           rsp_in.status = lkvt_pkg::STATUS_FULL;
                        end else begin
                           // append after the last entry
                           ram_wr_en         = 1'b1;
                           ram_wr_addr       = count_ff[lkvt_pkg::IDX_BITS-1:0];
                           ram_wr_data.key   = req_ff.key[lkvt_pkg::KEY_BITS-1:0];
                           ram_wr_data.value = req_ff.value[lkvt_pkg::VALUE_BITS-1:0];
                           count_in          = count_ff + lkvt_pkg::CNT_BITS'(1);
                        end
                     end
                     lkvt_pkg::OP_DELETE: begin
                        rsp_in.status = lkvt_pkg::STATUS_ABSENT;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end

         lkvt_pkg::ST_SHIFT: begin
            // entry arriving now moves down one place
            ram_wr_en = 1'b1;
            rd_idx_in = ram_rd_addr;
            if (last_entry) begin
               count_in  = count_ff - lkvt_pkg::CNT_BITS'(1);
               strobe_in = 1'b1;
               state_in  = lkvt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = lkvt_pkg::ST_IDLE;
         end
      endcase

      rsp_in.entry_total = 6'(count_in);
      rsp_in.is_full     = (count_in == lkvt_pkg::CNT_BITS'(lkvt_pkg::CAPACITY_ENTRIES));
   end

   assign busy        = (state_ff != lkvt_pkg::ST_IDLE);
   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

[rtl/core/lkvt_ram.sv]
// generic simple dual-port ram with registered read
module lkvt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
